// ----- rtl/core/stt_pkg.sv -----
package stt_pkg;

  // Result counts per input byte
  localparam int unsigned NumRes    = 4;
  localparam int unsigned CntWidth  = 3;   // holds 0 .. NumRes
  localparam int unsigned IdxWidth  = 2;   // indexes 0 .. NumRes-1

  // Bundle queue between front and back
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrWidth  = 2;
  localparam int unsigned QCntWidth  = 3;

  // Default widths of the position counters
  localparam int unsigned LineBitsDef   = 16;
  localparam int unsigned ColumnBitsDef = 12;

  // Event codes
  localparam logic [1:0] EvText  = 2'd0;
  localparam logic [1:0] EvDone  = 2'd1;
  localparam logic [1:0] EvError = 2'd2;

  // Token types
  localparam logic [2:0] TokIdent  = 3'd0;
  localparam logic [2:0] TokNumber = 3'd1;
  localparam logic [2:0] TokString = 3'd2;
  localparam logic [2:0] TokChar   = 3'd3;
  localparam logic [2:0] TokSymbol = 3'd4;
  localparam logic [2:0] TokEol    = 3'd5;

  // Error codes
  localparam logic [1:0] ErrUntermString = 2'd0;
  localparam logic [1:0] ErrBadChar      = 2'd1;
  localparam logic [1:0] ErrNoCloseQuote = 2'd2;
  localparam logic [1:0] ErrBadByte      = 2'd3;

  // Character constants
  localparam logic [7:0] ChLt     = 8'h3C;
  localparam logic [7:0] ChGt     = 8'h3E;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChEq     = 8'h3D;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChNl     = 8'h0A;
  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChDquote = 8'h22;
  localparam logic [7:0] ChSquote = 8'h27;

  // One result without its position fields
  typedef struct packed {
    logic [1:0] ev;
    logic [2:0] ttype;
    logic [7:0] tbyte;
    logic [1:0] code;
  } rec_t;

  localparam int unsigned RecWidth = $bits(rec_t);

  function automatic rec_t mk_rec(logic [1:0] ev, logic [2:0] ttype,
                                  logic [7:0] tbyte, logic [1:0] code);
    rec_t r;
    r.ev    = ev;
    r.ttype = ttype;
    r.tbyte = tbyte;
    r.code  = code;
    return r;
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
           (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

endpackage

// ----- rtl/core/stt_front.sv -----
module stt_front #(
  parameter int unsigned LINE_BITS   = stt_pkg::LineBitsDef,
  parameter int unsigned COLUMN_BITS = stt_pkg::ColumnBitsDef,
  localparam int unsigned BundleWidth = stt_pkg::CntWidth + LINE_BITS +
      stt_pkg::NumRes * (COLUMN_BITS + stt_pkg::RecWidth)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  logic [7:0]             char_i,
  output logic                   bundle_valid_o,
  output logic [BundleWidth-1:0] bundle_o
);

  localparam int unsigned RecW = stt_pkg::RecWidth;
  localparam int unsigned NRes = stt_pkg::NumRes;

  typedef enum logic [3:0] {
    ModeIdle, ModeIdent, ModeNumber, ModeString, ModeChOpen, ModeChGot,
    ModeSymHold, ModeSlashHold, ModeUnderHold, ModeDotHold, ModeComment, ModeHalt
  } mode_e;

  mode_e                  mode_q, mode_d;
  logic                   dot_q, dot_d;
  logic [7:0]             held_q, held_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [COLUMN_BITS-1:0] col_q, col_d;
  logic [COLUMN_BITS-1:0] tok_col_q, tok_col_d;

  // Handling of a byte that arrives between tokens
  stt_pkg::rec_t idle_rec [2];
  logic [1:0]    idle_n;
  mode_e         idle_mode;
  logic [7:0]    idle_held;
  logic          idle_dot_clr;
  logic          idle_line_inc;

  always_comb begin
    idle_rec[0]   = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokIdent, 8'd0, 2'd0);
    idle_rec[1]   = idle_rec[0];
    idle_n        = 2'd0;
    idle_mode     = ModeIdle;
    idle_held     = held_q;
    idle_dot_clr  = 1'b0;
    idle_line_inc = 1'b0;
    if (char_i == stt_pkg::ChNl) begin
      idle_rec[0]   = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokEol, 8'd0, 2'd0);
      idle_n        = 2'd1;
      idle_line_inc = 1'b1;
    end else if (stt_pkg::is_space(char_i)) begin
      idle_n = 2'd0;
    end else if (stt_pkg::is_alpha(char_i)) begin
      idle_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokIdent,
                                    stt_pkg::to_upper(char_i), 2'd0);
      idle_n      = 2'd1;
      idle_mode   = ModeIdent;
    end else if (stt_pkg::is_digit(char_i)) begin
      idle_rec[0]  = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokNumber, char_i, 2'd0);
      idle_n       = 2'd1;
      idle_dot_clr = 1'b1;
      idle_mode    = ModeNumber;
    end else if (char_i == stt_pkg::ChUnder) begin
      idle_held = char_i;
      idle_mode = ModeUnderHold;
    end else if (char_i == stt_pkg::ChDot) begin
      idle_held = char_i;
      idle_mode = ModeDotHold;
    end else if (char_i == stt_pkg::ChSlash) begin
      idle_held = char_i;
      idle_mode = ModeSlashHold;
    end else if (char_i == stt_pkg::ChLt || char_i == stt_pkg::ChGt ||
                 char_i == stt_pkg::ChBang || char_i == stt_pkg::ChEq) begin
      idle_held = char_i;
      idle_mode = ModeSymHold;
    end else if (char_i == stt_pkg::ChDquote) begin
      idle_mode = ModeString;
    end else if (char_i == stt_pkg::ChSquote) begin
      idle_mode = ModeChOpen;
    end else if (stt_pkg::is_punct(char_i)) begin
      idle_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokSymbol, char_i, 2'd0);
      idle_rec[1] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokSymbol, 8'd0, 2'd0);
      idle_n      = 2'd2;
    end else begin
      idle_rec[0] = stt_pkg::mk_rec(stt_pkg::EvError, stt_pkg::TokIdent, 8'd0,
                                    stt_pkg::ErrBadByte);
      idle_n      = 2'd1;
      idle_mode   = ModeHalt;
    end
  end

  // Mode-specific results, then the merged bundle
  stt_pkg::rec_t          pre_rec [3];
  logic [COLUMN_BITS-1:0] pre_col [3];
  logic [1:0]             pre_n;
  logic                   do_idle;
  stt_pkg::rec_t          res_rec [NRes];
  logic [COLUMN_BITS-1:0] res_col [NRes];
  logic [stt_pkg::CntWidth-1:0] res_n;

  always_comb begin
    logic [2:0] j;
    mode_d    = mode_q;
    dot_d     = dot_q;
    held_d    = held_q;
    line_d    = line_q;
    col_d     = col_q;
    tok_col_d = tok_col_q;
    pre_n     = 2'd0;
    do_idle   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      pre_rec[i] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokIdent, 8'd0, 2'd0);
      pre_col[i] = tok_col_q;
    end

    case (mode_q)
      ModeIdent: begin
        if (stt_pkg::is_alpha(char_i) || stt_pkg::is_digit(char_i) ||
            char_i == stt_pkg::ChUnder) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokIdent,
                                       stt_pkg::to_upper(char_i), 2'd0);
          pre_n      = 2'd1;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokIdent, 8'd0, 2'd0);
          pre_n      = 2'd1;
          do_idle    = 1'b1;
        end
      end
      ModeNumber: begin
        if (stt_pkg::is_digit(char_i)) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokNumber, char_i, 2'd0);
          pre_n      = 2'd1;
        end else if (char_i == stt_pkg::ChDot && !dot_q) begin
          dot_d      = 1'b1;
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokNumber, char_i, 2'd0);
          pre_n      = 2'd1;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokNumber, 8'd0, 2'd0);
          pre_n      = 2'd1;
          do_idle    = 1'b1;
        end
      end
      ModeString: begin
        if (char_i == stt_pkg::ChDquote) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokString, 8'd0, 2'd0);
          pre_n      = 2'd1;
          mode_d     = ModeIdle;
        end else if (char_i == stt_pkg::ChNl) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvError, stt_pkg::TokIdent, 8'd0,
                                       stt_pkg::ErrUntermString);
          pre_col[0] = col_q;
          pre_n      = 2'd1;
          mode_d     = ModeHalt;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokString, char_i, 2'd0);
          pre_n      = 2'd1;
        end
      end
      ModeChOpen: begin
        if (char_i == stt_pkg::ChNl || char_i == stt_pkg::ChSquote) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvError, stt_pkg::TokIdent, 8'd0,
                                       stt_pkg::ErrBadChar);
          pre_col[0] = col_q;
          pre_n      = 2'd1;
          mode_d     = ModeHalt;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokChar, char_i, 2'd0);
          pre_n      = 2'd1;
          mode_d     = ModeChGot;
        end
      end
      ModeChGot: begin
        if (char_i == stt_pkg::ChSquote) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokChar, 8'd0, 2'd0);
          pre_n      = 2'd1;
          mode_d     = ModeIdle;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvError, stt_pkg::TokIdent, 8'd0,
                                       stt_pkg::ErrNoCloseQuote);
          pre_col[0] = col_q;
          pre_n      = 2'd1;
          mode_d     = ModeHalt;
        end
      end
      ModeSymHold: begin
        pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokSymbol, held_q, 2'd0);
        if (char_i == stt_pkg::ChEq) begin
          pre_rec[1] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokSymbol, char_i, 2'd0);
          pre_rec[2] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokSymbol, 8'd0, 2'd0);
          pre_n      = 2'd3;
          mode_d     = ModeIdle;
        end else begin
          pre_rec[1] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokSymbol, 8'd0, 2'd0);
          pre_n      = 2'd2;
          do_idle    = 1'b1;
        end
      end
      ModeSlashHold: begin
        if (char_i == stt_pkg::ChSlash) begin
          mode_d = ModeComment;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokSymbol, held_q, 2'd0);
          pre_rec[1] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokSymbol, 8'd0, 2'd0);
          pre_n      = 2'd2;
          do_idle    = 1'b1;
        end
      end
      ModeUnderHold: begin
        if (stt_pkg::is_alpha(char_i)) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokIdent, held_q, 2'd0);
          pre_rec[1] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokIdent,
                                       stt_pkg::to_upper(char_i), 2'd0);
          pre_n      = 2'd2;
          mode_d     = ModeIdent;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokSymbol, held_q, 2'd0);
          pre_rec[1] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokSymbol, 8'd0, 2'd0);
          pre_n      = 2'd2;
          do_idle    = 1'b1;
        end
      end
      ModeDotHold: begin
        if (stt_pkg::is_digit(char_i)) begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokNumber, held_q, 2'd0);
          pre_rec[1] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokNumber, char_i, 2'd0);
          pre_n      = 2'd2;
          dot_d      = 1'b1;
          mode_d     = ModeNumber;
        end else begin
          pre_rec[0] = stt_pkg::mk_rec(stt_pkg::EvText, stt_pkg::TokSymbol, held_q, 2'd0);
          pre_rec[1] = stt_pkg::mk_rec(stt_pkg::EvDone, stt_pkg::TokSymbol, 8'd0, 2'd0);
          pre_n      = 2'd2;
          do_idle    = 1'b1;
        end
      end
      ModeComment: begin
        do_idle = (char_i == stt_pkg::ChNl);
      end
      ModeHalt: begin
        pre_n = 2'd0;
      end
      default: begin
        do_idle = 1'b1;
      end
    endcase

    if (do_idle) begin
      mode_d    = idle_mode;
      held_d    = idle_held;
      tok_col_d = col_q;
      if (idle_dot_clr) begin
        dot_d = 1'b0;
      end
      if (idle_line_inc && line_q != {LINE_BITS{1'b1}}) begin
        line_d = line_q + 1'b1;
      end
    end

    if (mode_q != ModeHalt) begin
      if (char_i == stt_pkg::ChNl) begin
        col_d = COLUMN_BITS'(1);
      end else if (col_q != {COLUMN_BITS{1'b1}}) begin
        col_d = col_q + 1'b1;
      end
    end

    // Merge: mode results first, then the between-tokens results
    res_n = stt_pkg::CntWidth'(pre_n) +
            (do_idle ? stt_pkg::CntWidth'(idle_n) : stt_pkg::CntWidth'(0));
    for (int i = 0; i < NRes; i++) begin
      j = 3'(i) - {1'b0, pre_n};
      if (3'(i) < {1'b0, pre_n}) begin
        res_rec[i] = pre_rec[i % 3];
        res_col[i] = pre_col[i % 3];
      end else if (j < 3'd2) begin
        res_rec[i] = idle_rec[j[0]];
        res_col[i] = col_q;
      end else begin
        res_rec[i] = idle_rec[0];
        res_col[i] = col_q;
      end
    end

    bundle_o = '0;
    for (int i = 0; i < NRes; i++) begin
      bundle_o[i*RecW +: RecW]                        = res_rec[i];
      bundle_o[NRes*RecW + i*COLUMN_BITS +: COLUMN_BITS] = res_col[i];
    end
    bundle_o[NRes*(RecW+COLUMN_BITS) +: LINE_BITS]    = line_q;
    bundle_o[BundleWidth-1 -: stt_pkg::CntWidth]       = res_n;
  end

  assign bundle_valid_o = accept_i && (res_n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= ModeIdle;
      dot_q     <= 1'b0;
      held_q    <= 8'd0;
      line_q    <= '0;
      col_q     <= COLUMN_BITS'(1);
      tok_col_q <= COLUMN_BITS'(1);
    end else if (accept_i) begin
      mode_q    <= mode_d;
      dot_q     <= dot_d;
      held_q    <= held_d;
      line_q    <= line_d;
      col_q     <= col_d;
      tok_col_q <= tok_col_d;
    end
  end

endmodule

// ----- rtl/core/stt_queue.sv -----
module stt_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  logic [WIDTH-1:0]                mem [stt_pkg::QueueDepth];
  logic [stt_pkg::QPtrWidth-1:0]   wptr_q, rptr_q;
  logic [stt_pkg::QCntWidth-1:0]   cnt_q;
  logic                            do_wr, do_rd;

  assign full_o  = (cnt_q == stt_pkg::QCntWidth'(stt_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_rd) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/stt_back.sv -----
module stt_back #(
  parameter int unsigned LINE_BITS   = stt_pkg::LineBitsDef,
  parameter int unsigned COLUMN_BITS = stt_pkg::ColumnBitsDef,
  localparam int unsigned BundleWidth = stt_pkg::CntWidth + LINE_BITS +
      stt_pkg::NumRes * (COLUMN_BITS + stt_pkg::RecWidth)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [BundleWidth-1:0] bundle_i,
  input  logic                   avail_i,
  input  logic                   take_i,
  output logic                   release_o,
  output stt_pkg::rec_t          rec_o,
  output logic [LINE_BITS-1:0]   line_o,
  output logic [COLUMN_BITS-1:0] col_o,
  output logic                   last_o
);

  localparam int unsigned RecW = stt_pkg::RecWidth;
  localparam int unsigned NRes = stt_pkg::NumRes;

  logic [stt_pkg::IdxWidth-1:0] idx_q, idx_d;
  logic [stt_pkg::CntWidth-1:0] cnt;
  logic                         fire;

  assign cnt    = bundle_i[BundleWidth-1 -: stt_pkg::CntWidth];
  assign line_o = bundle_i[NRes*(RecW+COLUMN_BITS) +: LINE_BITS];
  assign rec_o  = bundle_i[idx_q*RecW +: RecW];
  assign col_o  = bundle_i[NRes*RecW + idx_q*COLUMN_BITS +: COLUMN_BITS];
  assign last_o = ({1'b0, idx_q} == cnt - 1'b1);

  assign fire      = avail_i && take_i;
  assign release_o = fire && last_o;

  always_comb begin
    idx_d = idx_q;
    if (fire) begin
      idx_d = last_o ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ----- rtl/core/source_text_tokenizer.sv -----
// Streaming tokenizer for source text. Bytes go in through a queue-style
// port (push/full) and results come out through another (empty/pop).
// Spaces and // comments are dropped; each token is reported as a run of
// text-byte results (identifiers uppercased) and then one token-done result
// carrying its type, zero-based line and one-based start column. Symbols
// <= >= != == are joined; a leading '_' or '.', a lone '/' and a pending
// < > ! = wait for one more byte before they are classified. Any error
// (unterminated string, bad or unclosed character literal, unknown byte)
// gives one error result and the block then swallows all input until reset.
// Timing: the front end takes one byte per cycle whenever the bundle queue
// has room, and the result port drains one result per cycle while results
// wait and pop is high. A byte makes 0 to 4 results. last_of_run_o marks the
// final result caused by a byte. Line and column counters saturate at their
// all-ones value.
module source_text_tokenizer #(
  parameter int unsigned LINE_BITS   = stt_pkg::LineBitsDef,
  parameter int unsigned COLUMN_BITS = stt_pkg::ColumnBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input transaction side
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             char_in_i,
  // result transaction side
  output logic                   empty,
  input  logic                   pop,
  output logic [1:0]             event_res_o,
  output logic [2:0]             token_type_o,
  output logic [7:0]             text_byte_o,
  output logic [LINE_BITS-1:0]   line_number_o,
  output logic [COLUMN_BITS-1:0] start_column_o,
  output logic [1:0]             error_code_o,
  output logic                   last_of_run_o
);

  localparam int unsigned BundleWidth = stt_pkg::CntWidth + LINE_BITS +
      stt_pkg::NumRes * (COLUMN_BITS + stt_pkg::RecWidth);

  logic                   accept;
  logic                   bundle_valid;
  logic [BundleWidth-1:0] bundle_wr, bundle_rd;
  logic                   q_full, q_empty, q_release;
  stt_pkg::rec_t          rec;

  // A byte is taken whenever the queue can hold its bundle, even bytes
  // that make no result, so the front never waits on the back otherwise.
  assign full   = q_full;
  assign accept = push && !q_full;

  stt_front #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .char_i        (char_in_i),
    .bundle_valid_o(bundle_valid),
    .bundle_o      (bundle_wr)
  );

  // Short queue of per-byte result bundles decouples classify from emit.
  stt_queue #(
    .WIDTH(BundleWidth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (bundle_valid),
    .wdata_i(bundle_wr),
    .rd_i   (q_release),
    .rdata_o(bundle_rd),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Back end walks the head bundle one result per pop transaction.
  stt_back #(
    .LINE_BITS  (LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bundle_i (bundle_rd),
    .avail_i  (!q_empty),
    .take_i   (pop),
    .release_o(q_release),
    .rec_o    (rec),
    .line_o   (line_number_o),
    .col_o    (start_column_o),
    .last_o   (last_of_run_o)
  );

  assign empty        = q_empty;
  assign event_res_o  = rec.ev;
  assign token_type_o = rec.ttype;
  assign text_byte_o  = rec.tbyte;
  assign error_code_o = rec.code;

endmodule

// ----- tb/source_text_tokenizer_checker.sv -----
`timescale 1ns / 100ps

module source_text_tokenizer_checker #(
  parameter int unsigned LINE_BITS   = stt_pkg::LineBitsDef,
  parameter int unsigned COLUMN_BITS = stt_pkg::ColumnBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   full_i,
  input  logic [7:0]             char_in_i,
  input  logic                   empty_i,
  input  logic                   pop_i,
  input  logic [1:0]             event_res_i,
  input  logic [2:0]             token_type_i,
  input  logic [7:0]             text_byte_i,
  input  logic [LINE_BITS-1:0]   line_number_i,
  input  logic [COLUMN_BITS-1:0] start_column_i,
  input  logic [1:0]             error_code_i,
  input  logic                   last_of_run_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     result_count_o,
  output int                     token_count_o
);

  localparam logic [1:0] NoErr  = 2'd0;
  localparam logic [2:0] NoType = 3'd0;

  typedef enum logic [3:0] {
    ScanIdle, ScanIdent, ScanNumber, ScanString, ScanCharOpen, ScanCharGot,
    ScanSymHold, ScanSlashHold, ScanUnderHold, ScanDotHold, ScanComment, ScanHalted
  } scan_e;

  typedef struct packed {
    logic [1:0]             ev;
    logic [2:0]             ttype;
    logic [7:0]             tbyte;
    logic [LINE_BITS-1:0]   lnum;
    logic [COLUMN_BITS-1:0] scol;
    logic [1:0]             code;
    logic                   last;
  } lex_result_t;

  // lexer state
  scan_e                  mode;
  logic                   dot_seen;
  logic [7:0]             held;
  logic [LINE_BITS-1:0]   line_cnt;
  logic [COLUMN_BITS-1:0] col_cnt;
  logic [COLUMN_BITS-1:0] tok_col;

  lex_result_t byte_out[$];         // results of the byte being lexed
  lex_result_t pending_results[$];  // predicted, not yet popped

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_mark(logic [7:0] c);
    return (c >= 8'h21 && c <= 8'h2F) || (c >= 8'h3A && c <= 8'h40) ||
           (c >= 8'h5B && c <= 8'h60) || (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  function automatic void add_result(logic [1:0] ev, logic [2:0] tt, logic [7:0] b,
                                     logic [COLUMN_BITS-1:0] col, logic [1:0] code);
    lex_result_t r;
    r.ev    = ev;
    r.ttype = tt;
    r.tbyte = b;
    r.lnum  = line_cnt;
    r.scol  = col;
    r.code  = code;
    r.last  = 1'b0;
    byte_out = {byte_out, r};
  endfunction

  function automatic void add_text(logic [2:0] tt, logic [7:0] b);
    add_result(stt_pkg::EvText, tt, b, tok_col, NoErr);
  endfunction

  function automatic void add_done(logic [2:0] tt);
    add_result(stt_pkg::EvDone, tt, 8'h00, tok_col, NoErr);
  endfunction

  // errors report the column of the offending byte, then lock up
  function automatic void raise_error(logic [1:0] code);
    add_result(stt_pkg::EvError, NoType, 8'h00, col_cnt, code);
    mode = ScanHalted;
  endfunction

  function automatic void start_between(logic [7:0] c);
    tok_col = col_cnt;
    mode    = ScanIdle;
    if (c == stt_pkg::ChNl) begin
      add_done(stt_pkg::TokEol);
      if (line_cnt != '1) line_cnt = line_cnt + 1'b1;
    end else if (is_blank(c)) begin
      // dropped
    end else if (is_letter(c)) begin
      add_text(stt_pkg::TokIdent, upcase(c));
      mode = ScanIdent;
    end else if (is_numeral(c)) begin
      add_text(stt_pkg::TokNumber, c);
      dot_seen = 1'b0;
      mode     = ScanNumber;
    end else if (c == stt_pkg::ChUnder) begin
      held = c;
      mode = ScanUnderHold;
    end else if (c == stt_pkg::ChDot) begin
      held = c;
      mode = ScanDotHold;
    end else if (c == stt_pkg::ChSlash) begin
      held = c;
      mode = ScanSlashHold;
    end else if (c == stt_pkg::ChLt || c == stt_pkg::ChGt || c == stt_pkg::ChBang ||
                 c == stt_pkg::ChEq) begin
      held = c;
      mode = ScanSymHold;
    end else if (c == stt_pkg::ChDquote) begin
      mode = ScanString;
    end else if (c == stt_pkg::ChSquote) begin
      mode = ScanCharOpen;
    end else if (is_mark(c)) begin
      add_text(stt_pkg::TokSymbol, c);
      add_done(stt_pkg::TokSymbol);
    end else begin
      raise_error(stt_pkg::ErrBadByte);
    end
  endfunction

  // lookahead byte did not extend the held one: it becomes a lone symbol
  function automatic void flush_held(logic [7:0] c);
    add_text(stt_pkg::TokSymbol, held);
    add_done(stt_pkg::TokSymbol);
    start_between(c);
  endfunction

  function automatic void lex_byte(logic [7:0] c);
    byte_out.delete();
    if (mode == ScanHalted) return;
    case (mode)
      ScanIdent: begin
        if (is_letter(c) || is_numeral(c) || c == stt_pkg::ChUnder) begin
          add_text(stt_pkg::TokIdent, upcase(c));
        end else begin
          add_done(stt_pkg::TokIdent);
          start_between(c);
        end
      end
      ScanNumber: begin
        if (is_numeral(c)) begin
          add_text(stt_pkg::TokNumber, c);
        end else if (c == stt_pkg::ChDot && !dot_seen) begin
          dot_seen = 1'b1;
          add_text(stt_pkg::TokNumber, c);
        end else begin
          add_done(stt_pkg::TokNumber);
          start_between(c);
        end
      end
      ScanString: begin
        if (c == stt_pkg::ChDquote) begin
          add_done(stt_pkg::TokString);
          mode = ScanIdle;
        end else if (c == stt_pkg::ChNl) begin
          raise_error(stt_pkg::ErrUntermString);
        end else begin
          add_text(stt_pkg::TokString, c);
        end
      end
      ScanCharOpen: begin
        if (c == stt_pkg::ChNl || c == stt_pkg::ChSquote) begin
          raise_error(stt_pkg::ErrBadChar);
        end else begin
          add_text(stt_pkg::TokChar, c);
          mode = ScanCharGot;
        end
      end
      ScanCharGot: begin
        if (c == stt_pkg::ChSquote) begin
          add_done(stt_pkg::TokChar);
          mode = ScanIdle;
        end else begin
          raise_error(stt_pkg::ErrNoCloseQuote);
        end
      end
      ScanSymHold: begin
        if (c == stt_pkg::ChEq) begin
          add_text(stt_pkg::TokSymbol, held);
          add_text(stt_pkg::TokSymbol, c);
          add_done(stt_pkg::TokSymbol);
          mode = ScanIdle;
        end else begin
          flush_held(c);
        end
      end
      ScanSlashHold: begin
        if (c == stt_pkg::ChSlash) mode = ScanComment;
        else flush_held(c);
      end
      ScanUnderHold: begin
        if (is_letter(c)) begin
          add_text(stt_pkg::TokIdent, held);
          add_text(stt_pkg::TokIdent, upcase(c));
          mode = ScanIdent;
        end else begin
          flush_held(c);
        end
      end
      ScanDotHold: begin
        if (is_numeral(c)) begin
          add_text(stt_pkg::TokNumber, held);
          add_text(stt_pkg::TokNumber, c);
          dot_seen = 1'b1;
          mode     = ScanNumber;
        end else begin
          flush_held(c);
        end
      end
      ScanComment: begin
        if (c == stt_pkg::ChNl) start_between(c);
      end
      default: start_between(c);
    endcase
    if (c == stt_pkg::ChNl) col_cnt = COLUMN_BITS'(1);
    else if (col_cnt != '1) col_cnt = col_cnt + 1'b1;
    if (byte_out.size() > 0) byte_out[byte_out.size() - 1].last = 1'b1;
    pending_results = {pending_results, byte_out};
  endfunction

  function automatic string show(lex_result_t r);
    return $sformatf("ev=%0d type=%0d byte=%02h line=%0d col=%0d code=%0d last=%0b",
                     r.ev, r.ttype, r.tbyte, r.lnum, r.scol, r.code, r.last);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lex_result_t got_r;
    lex_result_t exp_r;
    if (!rst_ni) begin
      mode     = ScanIdle;
      dot_seen = 1'b0;
      held     = 8'h00;
      line_cnt = '0;
      col_cnt  = COLUMN_BITS'(1);
      tok_col  = COLUMN_BITS'(1);
      pending_results.delete();
    end else begin
      // output transaction: compare against the oldest prediction
      if (pop_i && !empty_i) begin
        got_r = '{event_res_i, token_type_i, text_byte_i, line_number_i,
                  start_column_i, error_code_i, last_of_run_i};
        result_count_o++;
        if (event_res_i == stt_pkg::EvDone) token_count_o++;
        if (pending_results.size() == 0) begin
          if (fail_count_o < 10) $display("%0t: unexpected result %s", $realtime, show(got_r));
          fail_count_o++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r.ev !== exp_r.ev || got_r.ttype !== exp_r.ttype ||
              got_r.tbyte !== exp_r.tbyte || got_r.lnum !== exp_r.lnum ||
              got_r.scol !== exp_r.scol || got_r.code !== exp_r.code ||
              got_r.last !== exp_r.last) begin
            if (fail_count_o < 10) begin
              $display("%0t: mismatch, expected %s", $realtime, show(exp_r));
              $display("%0t:           actual   %s", $realtime, show(got_r));
            end
            fail_count_o++;
          end
        end
      end
      // input transaction: predict what this byte produces
      if (push_i && !full_i) lex_byte(char_in_i);
    end
    pending_o = pending_results.size();
  end

endmodule

// ----- tb/source_text_tokenizer_tb.sv -----
`timescale 1ns / 100ps

module source_text_tokenizer_tb;

  localparam logic [7:0] ChSpace    = 8'h20;
  localparam logic [7:0] ChTab      = 8'h09;
  localparam int         QuietLimit = 2000;  // cycles with no transaction at all
  localparam int         LongHold   = 300;   // sink hold-off, far beyond the queue depth
  localparam int         PhaseBytes = 100;   // random bytes per idle/stall mix

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [7:0]  char_in;
  logic        empty;
  logic        pop;
  logic [1:0]  event_res;
  logic [2:0]  token_type;
  logic [7:0]  text_byte;
  logic [15:0] line_number;
  logic [11:0] start_column;
  logic [1:0]  error_code;
  logic        last_of_run;

  int fail_count;
  int pending;
  int result_count;
  int token_count;

  // knobs and counters of the source, sink and watchdog processes
  int   idle_pct;
  int   stall_pct;
  bit   hold_request;
  int   hold_left;
  int   bytes_sent;
  int   quiet_cycles;
  logic [1:0] err_kind;

  logic [7:0] token_bytes[$];

  source_text_tokenizer DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .char_in_i      (char_in),
    .empty          (empty),
    .pop            (pop),
    .event_res_o    (event_res),
    .token_type_o   (token_type),
    .text_byte_o    (text_byte),
    .line_number_o  (line_number),
    .start_column_o (start_column),
    .error_code_o   (error_code),
    .last_of_run_o  (last_of_run)
  );

  source_text_tokenizer_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .char_in_i      (char_in),
    .empty_i        (empty),
    .pop_i          (pop),
    .event_res_i    (event_res),
    .token_type_i   (token_type),
    .text_byte_i    (text_byte),
    .line_number_i  (line_number),
    .start_column_i (start_column),
    .error_code_i   (error_code),
    .last_of_run_i  (last_of_run),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .result_count_o (result_count),
    .token_count_o  (token_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Byte pickers. Everything random below stays inside well-formed tokens so
  // the lexer never halts before the closing error section: raw bytes with the
  // top bit set only ever land inside strings, character literals and comments,
  // where they are legal, and so do control codes but for 0x0B..0x0D as noise.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'h41 + 8'($urandom_range(0, 25));
    if ($urandom_range(0, 1) == 1) c = c + 8'd32;
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'h30 + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_any_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  // Noise: printable bytes and odd whitespace, never a quote (a stray quote
  // would open a literal we do not close).
  function automatic logic [7:0] pick_noise();
    logic [7:0] c;
    if ($urandom_range(0, 4) == 0) begin
      c = 8'h0B + 8'($urandom_range(0, 2));
    end else begin
      do c = 8'($urandom_range(32, 126));
      while (c == stt_pkg::ChDquote || c == stt_pkg::ChSquote);
    end
    return c;
  endfunction

  function automatic void put_byte(logic [7:0] b);
    token_bytes = {token_bytes, b};
  endfunction

  // Fills token_bytes with one token (plus maybe a separator). Tokens are
  // often glued together with no blank, which exercises the one-byte
  // lookahead and the done-then-restart path.
  function automatic void build_token();
    string puncts;
    int    kind;
    logic [7:0] c;
    puncts = "#$%&()*+,-.:;?@[]^_{|}~<>!=/";
    token_bytes.delete();
    kind = $urandom_range(0, 99);
    if (kind < 20) begin
      // identifier, sometimes with a leading underscore
      if ($urandom_range(0, 3) == 0) put_byte(stt_pkg::ChUnder);
      put_byte(pick_letter());
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 3))
          0:       put_byte(pick_digit());
          1:       put_byte(stt_pkg::ChUnder);
          default: put_byte(pick_letter());
        endcase
      end
    end else if (kind < 35) begin
      // number: leading dot form or digits with an optional dot
      if ($urandom_range(0, 4) == 0) begin
        put_byte(stt_pkg::ChDot);
        put_byte(pick_digit());
      end else begin
        repeat ($urandom_range(1, 4)) put_byte(pick_digit());
        if ($urandom_range(0, 1) == 1) put_byte(stt_pkg::ChDot);
      end
      repeat ($urandom_range(0, 3)) put_byte(pick_digit());
    end else if (kind < 45) begin
      // string, possibly empty, any bytes but quote and newline
      put_byte(stt_pkg::ChDquote);
      repeat ($urandom_range(0, 5)) put_byte(pick_any_but(stt_pkg::ChDquote, stt_pkg::ChNl));
      put_byte(stt_pkg::ChDquote);
    end else if (kind < 53) begin
      put_byte(stt_pkg::ChSquote);
      put_byte(pick_any_but(stt_pkg::ChSquote, stt_pkg::ChNl));
      put_byte(stt_pkg::ChSquote);
    end else if (kind < 73) begin
      case ($urandom_range(0, 2))
        0: begin
          // relational: < > ! = with an optional joined '='
          case ($urandom_range(0, 3))
            0:       c = stt_pkg::ChLt;
            1:       c = stt_pkg::ChGt;
            2:       c = stt_pkg::ChBang;
            default: c = stt_pkg::ChEq;
          endcase
          put_byte(c);
          if ($urandom_range(0, 1) == 1) put_byte(stt_pkg::ChEq);
        end
        1:       put_byte(stt_pkg::ChSlash);
        default: put_byte(8'(puncts[$urandom_range(0, puncts.len() - 1)]));
      endcase
    end else if (kind < 78) begin
      // line comment with arbitrary content
      put_byte(stt_pkg::ChSlash);
      put_byte(stt_pkg::ChSlash);
      repeat ($urandom_range(0, 8)) put_byte(pick_any_but(stt_pkg::ChNl, stt_pkg::ChNl));
      put_byte(stt_pkg::ChNl);
    end else if (kind < 86) begin
      put_byte(stt_pkg::ChNl);
    end else if (kind < 96) begin
      repeat ($urandom_range(1, 3)) put_byte(pick_noise());
    end else begin
      repeat ($urandom_range(1, 4)) put_byte(ChSpace);
    end
    if ($urandom_range(0, 99) < 60) begin
      put_byte(($urandom_range(0, 4) == 0) ? ChTab : ChSpace);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Source side. push stays high from one transaction to the next unless an
  // idle gap is rolled, so push sees at most one assignment per time step.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push    <= 1'b1;
    char_in <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(8'(s[i]));
  endtask

  task automatic send_token();
    build_token();
    foreach (token_bytes[i]) send_byte(token_bytes[i]);
  endtask

  // Sender goes quiet until every predicted result has been popped. Waiting
  // for an edge first lets the checker record the last input transaction.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
  endtask

  // ---------------------------------------------------------------------------
  // Sink side: random stalls per the current mix, plus one long hold-off on
  // request to back the result queue all the way up into full.
  // ---------------------------------------------------------------------------
  initial begin : sink
    pop = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_left    = LongHold;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog, no transaction for %0d cycles, %0d results outstanding",
               $realtime, QuietLimit, pending);
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : source
    int phase_bytes;
    rst_ni       = 1'b0;
    push         = 1'b0;
    char_in      = 8'h00;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b0;
    hold_left    = 0;
    bytes_sent   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: leading underscore and dot, a number hitting its second dot,
    // joined relationals, a lone slash, a char literal, a string holding the
    // byte extremes, an empty string, end of line.
    send_text("_a9 .5 1.2.3<=!=/'q'\"");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_text("\"\"\"\n");
    drain();

    // Random mixes: free-running, sparse source, stalling sink, both at 34%.
    // The first mix opens with the long sink hold-off while the source keeps
    // offering bytes, so the block fills and drops full on us.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 83; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 83; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      if (ph == 0) hold_request = 1'b1;
      phase_bytes = bytes_sent;
      while (bytes_sent - phase_bytes < PhaseBytes) send_token();
      drain();
    end

    // One error kind per run (the block only recovers through reset), then
    // bytes that a halted block must swallow silently.
    idle_pct  = 0;
    stall_pct = 0;
    err_kind = 2'($urandom_range(0, 3));
    send_byte(stt_pkg::ChNl);
    case (err_kind)
      stt_pkg::ErrUntermString: begin
        send_byte(stt_pkg::ChDquote);
        send_byte(pick_letter());
        send_byte(stt_pkg::ChNl);
      end
      stt_pkg::ErrBadChar: begin
        send_byte(stt_pkg::ChSquote);
        send_byte(($urandom_range(0, 1) == 1) ? stt_pkg::ChNl : stt_pkg::ChSquote);
      end
      stt_pkg::ErrNoCloseQuote: begin
        send_byte(stt_pkg::ChSquote);
        send_byte(pick_letter());
        send_byte(pick_any_but(stt_pkg::ChSquote, stt_pkg::ChSquote));
      end
      default: begin
        // anything outside letters, digits, whitespace and punctuation
        send_byte(pick_any_but(8'h20, 8'h20) | 8'h80);
      end
    endcase
    send_byte(8'h00);
    send_byte(8'hFF);
    repeat (20) send_byte(8'($urandom_range(0, 255)));
    drain();

    // anything the block still emits now has no prediction behind it
    repeat (32) @(posedge clk_i);

    $display("Sent %0d source bytes; checked %0d results in %0d tokens over four mixes",
             bytes_sent, result_count, token_count);
    $display("plus a full-queue hold-off; ended halted on error kind %0d.", err_kind);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/stt_pkg.sv
rtl/core/stt_front.sv
rtl/core/stt_queue.sv
rtl/core/stt_back.sv
rtl/core/source_text_tokenizer.sv
tb/source_text_tokenizer_checker.sv
tb/source_text_tokenizer_tb.sv
